@@ design/psg_pkg.sv @@
// shared types, constants and helpers for the parallax starfield generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package psg_pkg;

	// default sizing, handed down as the top level parameter defaults
	localparam int STAR_COUNT_DEF  = 64;
	localparam int LAYER_COUNT_DEF = 3;

	// fixed field widths
	localparam int X_W     = 18;   // 10 integer bits, 8 fraction bits
	localparam int Y_W     = 10;
	localparam int LAYER_W = 2;
	localparam int PROD_W  = 28;   // 16 x 12 product

	// generator constants
	localparam logic [31:0] LCG_MUL   = 32'd1664525;
	localparam logic [31:0] LCG_ADD   = 32'd1013904223;
	localparam logic [31:0] LCG_RESET = 32'd54321;

	localparam logic [9:0] GRAY_STEP = 10'd80;

	// register reset values
	localparam logic [9:0]  WIDTH_RST  = 10'd320;
	localparam logic [9:0]  HEIGHT_RST = 10'd120;
	localparam logic [11:0] NEAR_RST   = 12'd320;
	localparam logic [11:0] MID_RST    = 12'd800;
	localparam logic [11:0] FAR_RST    = 12'd1440;
	localparam logic [31:0] SEED_RST   = 32'd54321;

	// register indexes
	localparam logic [2:0] CFG_SCREEN_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_HORIZON_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_SPEED_NEAR     = 3'd2;
	localparam logic [2:0] CFG_SPEED_MID      = 3'd3;
	localparam logic [2:0] CFG_SPEED_FAR      = 3'd4;
	localparam logic [2:0] CFG_RNG_SEED       = 3'd5;

	// command codes
	localparam logic [1:0] CMD_INIT   = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_DRAW   = 2'd2;

	typedef struct packed {
		logic [9:0]  width;
		logic [9:0]  height;
		logic [11:0] speed_near;
		logic [11:0] speed_mid;
		logic [11:0] speed_far;
		logic [31:0] seed;
	} cfg_t;

	typedef struct packed {
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
	} star_t;

	typedef struct packed {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [15:0] color;
		logic        last;
	} pix_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic add;
	} lcg_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_X_MUL,
		ST_X_ADD,
		ST_X_SCL,
		ST_X_FIN,
		ST_ROW_MUL,
		ST_ROW_ADD,
		ST_ROW_SCL,
		ST_ROW_FIN,
		ST_WRITE,
		ST_UPD_READ,
		ST_UPD_CALC,
		ST_DRW_READ,
		ST_DRW_EMIT
	} state_t;

	// rgb565 gray of a layer, level (layer+1)*80 capped at 255
	function automatic logic [15:0] gray_of_layer(input logic [LAYER_W-1:0] layer);
		logic [9:0] lvl;
		lvl = (10'(layer) + 10'd1) * GRAY_STEP;
		if (lvl > 10'd255) begin
			lvl = 10'd255;
		end
		return {lvl[7:3], lvl[7:2], lvl[7:3]};
	endfunction

endpackage

`default_nettype wire

@@ design/parallax_starfield_generator.sv @@
// draw reads each star, then offers its pixel to the output register and waits
//   there while the output is stalled; init takes each star through the x and row
//   multiply, add, scale and finish states, then a write; update reads a star and
//   writes its new x; a star that wraps also takes the row states for a new row
// stars are handled one at a time with a shared multiplier; one request at a time
// reset: registers to defaults, all positions read as zero, generator at 54321
`timescale 1ns / 1ps
`default_nettype none

module parallax_starfield_generator
	import psg_pkg::*;
#(
	parameter int STAR_COUNT  = STAR_COUNT_DEF,
	parameter int LAYER_COUNT = LAYER_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] time_step,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [9:0]       pixel_x,
	output logic [9:0]       pixel_y,
	output logic [15:0]      pixel_color,
	output logic             last_star
);

	localparam int AW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

	cfg_t          cfg_q;
	lcg_ctrl_t     lcg_ctrl;
	logic [15:0]   fraction;
	logic          rd_en;
	logic          wr_en;
	logic [AW-1:0] addr;
	star_t         wdata;
	star_t         rdata;
	logic          pix_ready;
	logic          pix_valid;
	pix_t          pix;
	logic          busy;
	logic          start;
	logic          out_valid_q;
	pix_t          pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width      <= WIDTH_RST;
			cfg_q.height     <= HEIGHT_RST;
			cfg_q.speed_near <= NEAR_RST;
			cfg_q.speed_mid  <= MID_RST;
			cfg_q.speed_far  <= FAR_RST;
			cfg_q.seed       <= SEED_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:   cfg_q.width      <= cfg_data[9:0];
				CFG_HORIZON_HEIGHT: cfg_q.height     <= cfg_data[9:0];
				CFG_SPEED_NEAR:     cfg_q.speed_near <= cfg_data[11:0];
				CFG_SPEED_MID:      cfg_q.speed_mid  <= cfg_data[11:0];
				CFG_SPEED_FAR:      cfg_q.speed_far  <= cfg_data[11:0];
				CFG_RNG_SEED:       cfg_q.seed       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign in_stall = busy;
	assign start    = in_valid && !busy;

	psg_seq #(
		.STAR_COUNT  (STAR_COUNT),
		.LAYER_COUNT (LAYER_COUNT),
		.AW          (AW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_cmd (command),
		.start_dt  (time_step),
		.cfg       (cfg_q),
		.fraction  (fraction),
		.lcg_ctrl  (lcg_ctrl),
		.rd_en     (rd_en),
		.wr_en     (wr_en),
		.addr      (addr),
		.wdata     (wdata),
		.rdata     (rdata),
		.pix_ready (pix_ready),
		.pix_valid (pix_valid),
		.pix       (pix),
		.busy      (busy)
	);

	psg_lcg u_lcg (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (lcg_ctrl),
		.seed     (cfg_q.seed),
		.fraction (fraction)
	);

	psg_star_mem #(
		.DEPTH (STAR_COUNT),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (addr),
		.rd_data (rdata),
		.wr_en   (wr_en),
		.wr_addr (addr),
		.wr_data (wdata)
	);

	// output register, refilled as soon as the held pixel is taken
	assign pix_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pix_ready) begin
			out_valid_q <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid) begin
			pix_q <= pix;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pix_q.x;
	assign pixel_y     = pix_q.y;
	assign pixel_color = pix_q.color;
	assign last_star   = pix_q.last;

endmodule

`default_nettype wire

@@ design/psg_star_mem.sv @@
// star position memory: one read and one write port, registered read data
// entries never written since reset read as zero through per-entry valid bits
// depends on psg_pkg
`timescale 1ns / 1ps
`default_nettype none

module psg_star_mem
	import psg_pkg::*;
#(
	parameter int DEPTH = STAR_COUNT_DEF,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output star_t              rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire star_t         wr_data
);

	star_t            mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	star_t            rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ design/psg_lcg.sv @@
// 32-bit linear congruential generator, each step done as a registered
// multiply, then an add; exposes the top 16 bits as a fraction
// depends on psg_pkg
`timescale 1ns / 1ps
`default_nettype none

module psg_lcg
	import psg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lcg_ctrl_t   ctrl,
	input  wire logic [31:0] seed,
	output logic      [15:0] fraction
);

	logic [31:0] state_q;
	logic [31:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LCG_RESET;
		end else begin
			priority if (ctrl.load) begin
				state_q <= seed;
			end else if (ctrl.add) begin
				state_q <= prod_q + LCG_ADD;
			end
		end
	end

	// product keeps only the low word, modulo 2^32
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_q <= state_q * LCG_MUL;
		end
	end

	assign fraction = state_q[31:16];

endmodule

`default_nettype wire

@@ design/psg_seq.sv @@
// command sequencer: walks the stars through the position memory,
// read-modify-write with one shared 16x12 multiplier
// depends on psg_pkg, drives psg_star_mem and psg_lcg from the top level
`timescale 1ns / 1ps
`default_nettype none

module psg_seq
	import psg_pkg::*;
#(
	parameter int STAR_COUNT  = STAR_COUNT_DEF,
	parameter int LAYER_COUNT = LAYER_COUNT_DEF,
	parameter int AW          = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    start_cmd,
	input  wire logic [15:0]   start_dt,
	input  wire cfg_t          cfg,
	input  wire logic [15:0]   fraction,
	output lcg_ctrl_t          lcg_ctrl,
	output logic               rd_en,
	output logic               wr_en,
	output logic [AW-1:0]      addr,
	output star_t              wdata,
	input  wire star_t         rdata,
	input  wire logic          pix_ready,
	output logic               pix_valid,
	output pix_t               pix,
	output logic               busy
);

	localparam logic [AW-1:0]      IDX_LAST = AW'(STAR_COUNT - 1);
	localparam logic [LAYER_W-1:0] LAY_LAST = LAYER_W'(LAYER_COUNT - 1);

	state_t              state_q, state_d;
	logic [1:0]          cmd_q;
	logic [15:0]         dt_q;
	logic [AW-1:0]       idx_q;
	logic [LAYER_W-1:0]  lay_q;
	logic [PROD_W-1:0]   prod_q;
	logic [X_W-1:0]      x_q;
	logic [Y_W-1:0]      y_q;

	logic                idx_last;
	logic [11:0]         speed;
	logic [15:0]         mul_a;
	logic [11:0]         mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic                mul_en;
	logic [15:0]         delta;
	logic signed [X_W:0] diff;
	logic signed [X_W:0] wrapped;
	logic [X_W-1:0]      x_upd;

	assign idx_last = (idx_q == IDX_LAST);

	always_comb begin
		priority if (lay_q == 2'd0) begin
			speed = cfg.speed_near;
		end else if (lay_q == 2'd1) begin
			speed = cfg.speed_mid;
		end else begin
			speed = cfg.speed_far;
		end
	end

	assign mul_p = mul_a * mul_b;

	// scroll step: delta in q.8 pixels, wrap by the screen width once
	assign delta   = prod_q[27:12];
	assign diff    = $signed({1'b0, rdata.x}) - $signed({3'b0, delta});
	assign wrapped = diff + $signed({1'b0, cfg.width, 8'b0});
	always_comb begin
		if (!diff[X_W]) begin
			x_upd = diff[X_W-1:0];
		end else if (wrapped[X_W]) begin
			x_upd = '0;
		end else begin
			x_upd = wrapped[X_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					priority if (start_cmd == CMD_INIT) begin
						state_d = ST_X_MUL;
					end else if (start_cmd == CMD_UPDATE) begin
						state_d = ST_UPD_READ;
					end else if (start_cmd == CMD_DRAW) begin
						state_d = ST_DRW_READ;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_X_MUL:    state_d = ST_X_ADD;
			ST_X_ADD:    state_d = ST_X_SCL;
			ST_X_SCL:    state_d = ST_X_FIN;
			ST_X_FIN:    state_d = ST_ROW_MUL;
			ST_ROW_MUL:  state_d = ST_ROW_ADD;
			ST_ROW_ADD:  state_d = ST_ROW_SCL;
			ST_ROW_SCL:  state_d = ST_ROW_FIN;
			ST_ROW_FIN:  state_d = ST_WRITE;
			ST_WRITE: begin
				if (idx_last) begin
					state_d = ST_IDLE;
				end else if (cmd_q == CMD_INIT) begin
					state_d = ST_X_MUL;
				end else begin
					state_d = ST_UPD_READ;
				end
			end
			ST_UPD_READ: state_d = ST_UPD_CALC;
			ST_UPD_CALC: state_d = diff[X_W] ? ST_ROW_MUL : ST_WRITE;
			ST_DRW_READ: state_d = ST_DRW_EMIT;
			ST_DRW_EMIT: begin
				if (pix_ready) begin
					state_d = idx_last ? ST_IDLE : ST_DRW_READ;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs per state
	always_comb begin
		lcg_ctrl  = '0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		pix_valid = 1'b0;
		mul_en    = 1'b0;
		mul_a     = fraction;
		mul_b     = 12'd0;
		unique case (state_q)
			ST_IDLE:     lcg_ctrl.load = start && (start_cmd == CMD_INIT);
			ST_X_MUL,
			ST_ROW_MUL:  lcg_ctrl.mul = 1'b1;
			ST_X_ADD,
			ST_ROW_ADD:  lcg_ctrl.add = 1'b1;
			ST_X_SCL: begin
				mul_en = 1'b1;
				mul_b  = {2'b0, cfg.width};
			end
			ST_ROW_SCL: begin
				mul_en = 1'b1;
				mul_b  = {2'b0, cfg.height};
			end
			ST_UPD_READ: begin
				rd_en  = 1'b1;
				mul_en = 1'b1;
				mul_a  = dt_q;
				mul_b  = speed;
			end
			ST_DRW_READ: rd_en = 1'b1;
			ST_WRITE:    wr_en = 1'b1;
			ST_DRW_EMIT: pix_valid = 1'b1;
			default: begin
			end
		endcase
	end

	assign addr      = idx_q;
	assign wdata.x   = x_q;
	assign wdata.y   = y_q;
	assign pix.x     = rdata.x[X_W-1:8];
	assign pix.y     = rdata.y;
	assign pix.color = gray_of_layer(lay_q);
	assign pix.last  = idx_last;
	assign busy      = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_INIT;
			idx_q   <= '0;
			lay_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && start) begin
				cmd_q <= start_cmd;
				idx_q <= '0;
				lay_q <= '0;
			end else if ((state_q == ST_WRITE) ||
			             (state_q == ST_DRW_EMIT && pix_ready)) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
				lay_q <= (idx_last || lay_q == LAY_LAST) ? '0 : lay_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			dt_q <= start_dt;
		end
		if (mul_en) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_X_FIN) begin
			x_q <= prod_q[25:8];
		end else if (state_q == ST_UPD_CALC) begin
			x_q <= x_upd;
		end
		if (state_q == ST_ROW_FIN) begin
			y_q <= prod_q[25:16];
		end else if (state_q == ST_UPD_CALC) begin
			y_q <= rdata.y;
		end
	end

	a_no_write_on_draw: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (cmd_q != CMD_DRAW))
		else $error("star memory written during a draw run");

	a_lcg_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({lcg_ctrl.load, lcg_ctrl.mul, lcg_ctrl.add}))
		else $error("generator given more than one operation");

	a_layer_range: assert property (@(posedge clk) disable iff (!arst_n)
		(lay_q <= LAY_LAST))
		else $error("layer counter out of range");

	a_last_write_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && idx_last) |=> (state_q == ST_IDLE))
		else $error("sequencer did not stop after the last star");

endmodule

`default_nettype wire
